[rtl/md4_pkg.sv]
// ----------------------------------------------------------------------------
// md4_pkg: shared types, constants and round tables for the MD4 core
// Holds the controller/datapath command and status structs, the sequencer
// state type, the initial chaining values and the per-round lookup functions.
// ----------------------------------------------------------------------------
package md4_pkg;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [31:0] KR2 = 32'h5A827999;
  localparam logic [31:0] KR3 = 32'h6ED9EBA1;
  localparam logic [7:0]  PadBit    = 8'h80;
  localparam logic [3:0]  CntFull   = 4'd8;
  localparam logic [5:0]  LastRound = 6'd47;
  localparam logic [5:0]  LastByte  = 6'd63;
  localparam logic [1:0]  GrpF = 2'd0;
  localparam logic [1:0]  GrpG = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FIN,
    ST_LEN,
    ST_OUT0,
    ST_OUT1
  } md4_state_e;

  typedef struct packed {
    logic       accept;
    logic       pad;
    logic       len;
    logic       clear_low;
    logic       comp_load;
    logic       comp_round;
    logic [5:0] rnd;
    logic       comp_fin;
    logic       out_hi;
    logic       init;
  } md4_cmd_t;

  typedef struct packed {
    logic wrap;
    logic fill_hi;
  } md4_stat_t;

  // message word used by a round
  function automatic logic [3:0] md4_msg_idx(input logic [5:0] rnd);
    logic [3:0] idx;
    case (rnd[5:4])
      GrpF:    idx = rnd[3:0];
      GrpG:    idx = {rnd[1:0], rnd[3:2]};
      default: idx = {rnd[0], rnd[1], rnd[2], rnd[3]};
    endcase
    return idx;
  endfunction

  // left-rotate amount of a round
  function automatic logic [4:0] md4_rot(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      4'b1011: s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

endpackage

[rtl/md4_in_if.sv]
// ----------------------------------------------------------------------------
// md4_in_if: message byte channel
// Valid/ready channel carrying one message byte, its valid bit count and
// the end-of-message flag.
// ----------------------------------------------------------------------------
interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] bit_count;
  logic       last;

  modport source (output valid, output data_byte, output bit_count, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input bit_count, input last,
                  output ready);
endinterface

[rtl/md4_out_if.sv]
// ----------------------------------------------------------------------------
// md4_out_if: digest channel
// Valid/ready channel carrying one half of the 16-byte digest per transaction.
// ----------------------------------------------------------------------------
interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic        part_last;

  modport source (output valid, output digest_part, output part_last, input ready);
  modport sink   (input valid, input digest_part, input part_last, output ready);
endinterface

[rtl/md4_ctrl.sv]
// ----------------------------------------------------------------------------
// md4_ctrl: MD4 sequencer
// Steps the core through byte intake, padding, length insertion, the 48
// compression rounds and the two digest transactions.
// ----------------------------------------------------------------------------
module md4_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              in_last_i,
  input  logic              out_fire_i,
  input  md4_pkg::md4_stat_t stat_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output logic              part_last_o,
  output md4_pkg::md4_cmd_t  cmd_o
);
  import md4_pkg::*;

  md4_state_e state_q, state_d;
  md4_state_e ret_q, ret_d;
  logic       extra_q, extra_d;
  logic [5:0] rnd_q, rnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      extra_q <= 1'b0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      extra_q <= extra_d;
      rnd_q   <= rnd_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    extra_d     = extra_q;
    rnd_d       = rnd_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    part_last_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.wrap) begin
            cmd_o.comp_load = 1'b1;
            rnd_d   = '0;
            state_d = ST_COMP;
            ret_d   = in_last_i ? ST_PAD : ST_IDLE;
          end else if (in_last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.pad = 1'b1;
        extra_d   = stat_i.fill_hi;
        if (stat_i.fill_hi) begin
          cmd_o.comp_load = 1'b1;
          rnd_d   = '0;
          state_d = ST_COMP;
          ret_d   = ST_LEN;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd_o.len       = 1'b1;
        cmd_o.clear_low = extra_q;
        cmd_o.comp_load = 1'b1;
        rnd_d   = '0;
        state_d = ST_COMP;
        ret_d   = ST_OUT0;
      end
      ST_COMP: begin
        cmd_o.comp_round = 1'b1;
        cmd_o.rnd        = rnd_q;
        rnd_d            = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.comp_fin = 1'b1;
        state_d        = ret_q;
      end
      ST_OUT0: begin
        out_valid_o = 1'b1;
        if (out_fire_i) begin
          state_d = ST_OUT1;
        end
      end
      ST_OUT1: begin
        out_valid_o  = 1'b1;
        part_last_o  = 1'b1;
        cmd_o.out_hi = 1'b1;
        if (out_fire_i) begin
          cmd_o.init = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/md4_dpath.sv]
// ----------------------------------------------------------------------------
// md4_dpath: MD4 datapath
// Block buffer, fill count, bit length, chaining words and the single
// round unit shared by all 48 compression steps.
// ----------------------------------------------------------------------------
module md4_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md4_pkg::md4_cmd_t  cmd_i,
  input  logic [7:0]        data_byte_i,
  input  logic [3:0]        bit_count_i,
  input  logic              last_i,
  output md4_pkg::md4_stat_t stat_o,
  output logic [63:0]       digest_part_o
);
  import md4_pkg::*;

  logic [31:0] buf_q [16];
  logic [31:0] chain_q [4];
  logic [5:0]  fill_q;
  logic [63:0] total_q;
  logic [7:0]  pad_byte_q;
  logic [31:0] va_q, vb_q, vc_q, vd_q;

  logic        cnt_full;
  logic [3:0]  cnt_sat;
  logic [7:0]  keep;
  logic [7:0]  pad_byte_d;
  logic [31:0] f_val, k_val, msg_word, sum, rot_res;
  logic [63:0] rot_dbl;
  logic [4:0]  rot_amt;

  assign cnt_full = bit_count_i[3];
  assign cnt_sat  = cnt_full ? CntFull : bit_count_i;
  assign keep     = ~(8'hFF >> bit_count_i[2:0]);
  assign pad_byte_d = cnt_full ? PadBit
                    : ((data_byte_i & keep) | (PadBit >> bit_count_i[2:0]));

  assign stat_o.wrap    = cnt_full && (fill_q == LastByte);
  assign stat_o.fill_hi = (fill_q[5:3] == 3'b111);

  assign digest_part_o = cmd_i.out_hi ? {chain_q[3], chain_q[2]}
                                      : {chain_q[1], chain_q[0]};

  // round unit
  always_comb begin
    case (cmd_i.rnd[5:4])
      GrpF: begin
        f_val = (vb_q & vc_q) | (~vb_q & vd_q);
        k_val = '0;
      end
      GrpG: begin
        f_val = (vb_q & vc_q) | (vb_q & vd_q) | (vc_q & vd_q);
        k_val = KR2;
      end
      default: begin
        f_val = vb_q ^ vc_q ^ vd_q;
        k_val = KR3;
      end
    endcase
    msg_word = buf_q[md4_msg_idx(cmd_i.rnd)];
    rot_amt  = md4_rot(cmd_i.rnd);
    sum      = va_q + f_val + msg_word + k_val;
    rot_dbl  = {sum, sum} << rot_amt;
    rot_res  = rot_dbl[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= IvA;
      chain_q[1] <= IvB;
      chain_q[2] <= IvC;
      chain_q[3] <= IvD;
      fill_q     <= '0;
      total_q    <= '0;
    end else if (cmd_i.init) begin
      chain_q[0] <= IvA;
      chain_q[1] <= IvB;
      chain_q[2] <= IvC;
      chain_q[3] <= IvD;
      fill_q     <= '0;
      total_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (cnt_full) begin
          fill_q <= fill_q + 6'd1;
        end
        if (cnt_full || last_i) begin
          total_q <= total_q + {60'd0, cnt_sat};
        end
      end
      if (cmd_i.comp_fin) begin
        chain_q[0] <= chain_q[0] + va_q;
        chain_q[1] <= chain_q[1] + vb_q;
        chain_q[2] <= chain_q[2] + vc_q;
        chain_q[3] <= chain_q[3] + vd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pad_byte_q <= pad_byte_d;
      if (cnt_full) begin
        buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= data_byte_i;
      end
    end
    if (cmd_i.pad) begin
      for (int w = 0; w < 16; w++) begin
        for (int l = 0; l < 4; l++) begin
          if ({4'(w), 2'(l)} == fill_q) begin
            buf_q[w][8*l +: 8] <= pad_byte_q;
          end else if ({4'(w), 2'(l)} > fill_q) begin
            buf_q[w][8*l +: 8] <= '0;
          end
        end
      end
    end
    if (cmd_i.len) begin
      if (cmd_i.clear_low) begin
        for (int w = 0; w < 14; w++) begin
          buf_q[w] <= '0;
        end
      end
      buf_q[14] <= total_q[31:0];
      buf_q[15] <= total_q[63:32];
    end
    if (cmd_i.comp_load) begin
      va_q <= chain_q[0];
      vb_q <= chain_q[1];
      vc_q <= chain_q[2];
      vd_q <= chain_q[3];
    end else if (cmd_i.comp_round) begin
      va_q <= vd_q;
      vb_q <= rot_res;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

endmodule

[rtl/md4_message_digest_core.sv]
// ----------------------------------------------------------------------------
// md4_message_digest_core: MD4 message digest (RFC 1320)
// Byte-stream MD4 engine with bit-granular final byte and two-part digest.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the core is idle; the last
// item may carry 0 to 7 valid leading bits. Every 64th byte starts a block
// compression that runs 48 rounds through one shared round unit, one round
// per cycle, then folds the result into the chaining words; the input is
// held off until the fold is done. After the last item the core pads the
// block, compresses an extra block when the pad byte falls at byte 56 or
// later, inserts the length and compresses the final block, then offers
// the digest as two transactions (bytes 0..7, then 8..15).
// Input is not taken again until the second digest transaction is done.
module md4_message_digest_core (
  input  logic clk_i,
  input  logic rst_ni,
  md4_in_if.sink    in_i,
  md4_out_if.source out_o
);
  import md4_pkg::*;

  md4_cmd_t  cmd;
  md4_stat_t stat;
  logic      in_fire;
  logic      out_fire;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  md4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_last_i   (in_i.last),
    .out_fire_i  (out_fire),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .part_last_o (out_o.part_last),
    .cmd_o       (cmd)
  );

  md4_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_i.data_byte),
    .bit_count_i   (in_i.bit_count),
    .last_i        (in_i.last),
    .stat_o        (stat),
    .digest_part_o (out_o.digest_part)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_o.valid && in_i.ready))
    else $error("input ready while digest pending");

  a_second_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_o.part_last) |=> (out_o.valid && out_o.part_last))
    else $error("second digest half missing");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.part_last) |=> (in_i.ready && !out_o.valid))
    else $error("core not idle after digest");

  a_last_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last) |=> !in_i.ready)
    else $error("last item did not start padding");

endmodule

[tb/md4_message_digest_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_message_digest_core_test: self-checking bench for the MD4 digest core
// Streams messages byte by byte through the input channel, computes each
// expected digest with an independent MD4 model, and compares both digest
// halves field by field. Covers empty, short, partial-byte and block-boundary
// messages, ignored and saturated bit counts, random idling on both channels
// and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module md4_message_digest_core_test;

  localparam logic [31:0] INIT_A      = 32'h67452301;
  localparam logic [31:0] INIT_B      = 32'hefcdab89;
  localparam logic [31:0] INIT_C      = 32'h98badcfe;
  localparam logic [31:0] INIT_D      = 32'h10325476;
  localparam logic [31:0] ROUND2_K    = 32'h5A827999;
  localparam logic [31:0] ROUND3_K    = 32'h6ED9EBA1;
  localparam int          LEN_BIT_POS = 448;
  localparam int          IDLE_PCT    = 36;
  localparam int          RANDOM_ITEMS = 440;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          MAX_SHOWN   = 10;

  typedef struct packed {
    logic [63:0] digest_part;
    logic        part_last;
  } digest_half_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  md4_in_if  in_if ();
  md4_out_if out_if ();

  md4_message_digest_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // digest model state
  logic [31:0]  md_chain [4];
  logic [7:0]   md_block [64];
  logic [5:0]   md_fill;
  logic [63:0]  md_total_bits;
  digest_half_t digest_q [$];

  int  cycle_count    = 0;
  int  item_count     = 0;
  int  ignored_count  = 0;
  int  message_count  = 0;
  int  checked_count  = 0;
  int  mismatch_count = 0;
  int  hold_request   = 0;
  bit  in_idle_on     = 1'b1;
  bit  out_idle_on    = 1'b1;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic int round_shift(input int grp, input int pos);
    int s;
    case (grp * 4 + pos)
      0:  s = 3;
      1:  s = 7;
      2:  s = 11;
      3:  s = 19;
      4:  s = 3;
      5:  s = 5;
      6:  s = 9;
      7:  s = 13;
      8:  s = 3;
      9:  s = 9;
      10: s = 11;
      default: s = 15;
    endcase
    return s;
  endfunction

  function automatic void md_restart();
    md_chain[0]   = INIT_A;
    md_chain[1]   = INIT_B;
    md_chain[2]   = INIT_C;
    md_chain[3]   = INIT_D;
    md_fill       = '0;
    md_total_bits = '0;
  endfunction

  function automatic void md_compress();
    logic [31:0] w [16];
    logic [31:0] v [4];
    logic [31:0] fb, fc, fd, f, k;
    int          t, grp, j, widx;
    for (int i = 0; i < 16; i++)
      w[i] = {md_block[4*i+3], md_block[4*i+2], md_block[4*i+1], md_block[4*i]};
    for (int i = 0; i < 4; i++) v[i] = md_chain[i];
    for (int r = 0; r < 48; r++) begin
      t   = (4 - (r % 4)) % 4;
      fb  = v[(t + 1) % 4];
      fc  = v[(t + 2) % 4];
      fd  = v[(t + 3) % 4];
      grp = r / 16;
      j   = r % 16;
      case (grp)
        0: begin
          f    = (fb & fc) | (~fb & fd);
          k    = '0;
          widx = j;
        end
        1: begin
          f    = (fb & fc) | (fb & fd) | (fc & fd);
          k    = ROUND2_K;
          widx = (j % 4) * 4 + j / 4;
        end
        default: begin
          f    = fb ^ fc ^ fd;
          k    = ROUND3_K;
          widx = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
        end
      endcase
      v[t] = rol32(v[t] + f + w[widx] + k, round_shift(grp, r % 4));
    end
    for (int i = 0; i < 4; i++) md_chain[i] = md_chain[i] + v[i];
  endfunction

  function automatic void md_absorb(input logic [7:0] b);
    md_block[md_fill] = b;
    md_fill           = md_fill + 6'd1;
    md_total_bits     = md_total_bits + 64'd8;
    if (md_fill == 6'd0) md_compress();
  endfunction

  function automatic void predict_digest(input logic [7:0] data, input logic [3:0] cnt,
                                         input logic last);
    int           n, pos;
    digest_half_t half;
    n = (cnt > 4'd8) ? 8 : int'(cnt);
    if (!last) begin
      if (n == 8) md_absorb(data);
      return;
    end
    if (n == 8) begin
      md_absorb(data);
      n = 0;
    end
    pos = int'(md_fill);
    if (n > 0) begin
      md_block[pos] = (data & 8'(16'hFF00 >> n)) | 8'(8'h80 >> n);
      md_total_bits = md_total_bits + 64'(n);
    end else begin
      md_block[pos] = 8'h80;
    end
    for (int i = pos + 1; i < 64; i++) md_block[i] = 8'h00;
    if (pos * 8 + n >= LEN_BIT_POS) begin
      md_compress();
      for (int i = 0; i < 56; i++) md_block[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) md_block[56 + i] = md_total_bits[8*i +: 8];
    md_compress();
    half.digest_part = {md_chain[1], md_chain[0]};
    half.part_last   = 1'b0;
    digest_q.push_back(half);
    half.digest_part = {md_chain[3], md_chain[2]};
    half.part_last   = 1'b1;
    digest_q.push_back(half);
    md_restart();
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, exp_val, act_val);
  endtask

  // digest checker
  always @(posedge clk_i) begin
    digest_half_t exp_half;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (digest_q.size() == 0) begin
        note_mismatch("unexpected transaction", '0, out_if.digest_part);
      end else begin
        exp_half = digest_q.pop_front();
        checked_count++;
        if (out_if.digest_part !== exp_half.digest_part)
          note_mismatch("digest_part", exp_half.digest_part, out_if.digest_part);
        if (out_if.part_last !== exp_half.part_last)
          note_mismatch("part_last", 64'(exp_half.part_last), 64'(out_if.part_last));
      end
    end
  end

  // output ready, with random idling and long hold-offs
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= !(out_idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest halves outstanding",
               cycle_count, digest_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // one input transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] data, input logic [3:0] cnt, input logic last);
    while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= data;
    in_if.bit_count <= cnt;
    in_if.last      <= last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    predict_digest(data, cnt, last);
    item_count++;
    if (last) message_count++;
    if (!last && cnt < 4'd8) ignored_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [3:0] random_full_count();
    return ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
  endfunction

  // whole bytes then a closing item; returns the number of data items sent
  task automatic send_message(input int n_bytes, input logic [3:0] tail_cnt,
                              input int noise_pct, output int sent);
    sent = 0;
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_byte(8'($urandom), 4'($urandom_range(7)), 1'b0);
      send_byte(8'($urandom), random_full_count(), 1'b0);
      sent++;
    end
    send_byte(8'($urandom), tail_cnt, 1'b1);
    sent++;
  endtask

  function automatic logic [3:0] random_tail_count();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 4'd8;
    if (r < 7) return 4'($urandom_range(7));
    if (r == 7) return 4'($urandom_range(15, 9));
    return 4'd0;
  endfunction

  task automatic test_short_messages();
    send_byte(8'h00, 4'd0, 1'b1);
    send_byte(8'h61, 4'd8, 1'b0);
    send_byte(8'h62, 4'd8, 1'b0);
    send_byte(8'h63, 4'd8, 1'b1);
    send_byte(8'hFF, 4'd1, 1'b1);
    send_byte(8'h00, 4'd8, 1'b0);
    send_byte(8'hFF, 4'd7, 1'b1);
    send_byte(8'h5A, 4'd3, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_byte(8'hFF, 4'd7, 1'b0);
    send_byte(8'h00, 4'd0, 1'b0);
    send_byte(8'hFF, 4'd8, 1'b0);
    send_byte(8'h00, 4'd15, 1'b0);
    send_byte(8'hA5, 4'd15, 1'b1);
    send_byte(8'hFF, 4'd0, 1'b1);
    send_byte(8'h00, 4'd8, 1'b1);
    send_byte(8'hFF, 4'd8, 1'b1);
    send_byte(8'h3C, 4'd9, 1'b1);
  endtask

  task automatic test_output_stall();
    int sent;
    in_idle_on   = 1'b0;
    out_idle_on  = 1'b0;
    hold_request = 400;
    for (int m = 0; m < 6; m++) send_message(4, 4'd8, 0, sent);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_random_messages();
    int boundary_len [5];
    int data_items, msgs, n_bytes, r, sent;
    boundary_len = '{55, 56, 63, 64, 120};
    data_items   = 0;
    msgs         = 0;
    while (data_items < RANDOM_ITEMS || msgs < 8) begin
      in_idle_on  = !(data_items >= 200 && data_items < 320);
      out_idle_on = in_idle_on;
      if (msgs < 5) begin
        n_bytes = boundary_len[msgs];
      end else begin
        r = $urandom_range(99);
        if (r < 65)      n_bytes = $urandom_range(8);
        else if (r < 85) n_bytes = $urandom_range(70, 50);
        else if (r < 93) n_bytes = $urandom_range(130, 110);
        else             n_bytes = $urandom_range(2);
      end
      send_message(n_bytes, random_tail_count(), 5, sent);
      data_items += sent;
      msgs++;
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    int errors;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.bit_count = '0;
    in_if.last      = 1'b0;
    for (int i = 0; i < 64; i++) md_block[i] = 8'h00;
    md_restart();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_messages();
    test_field_extremes();
    test_output_stall();
    test_random_messages();

    in_if.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    errors = mismatch_count + digest_q.size();
    $display("%0d messages in %0d input transactions (%0d ignored partial bytes)",
             message_count, item_count, ignored_count);
    $display("%0d digest halves checked, %0d errors", checked_count, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
